### rtl/core/cire_pkg.sv
// Package for the compact instruction execute block: fault codes, cycle costs
// and a shared helper function. No dependencies.
`default_nettype none
package cire_pkg;
    localparam int unsigned XLEN = 32;
    typedef logic [XLEN-1:0] t_word;

    typedef enum logic [2:0] {
        FAULT_NONE      = 3'd0,
        FAULT_UNDEF     = 3'd1,
        FAULT_BAD_COND  = 3'd2,
        FAULT_BAD_MISC  = 3'd3,
        FAULT_NOT_HERE  = 3'd4
    } t_fault;

    localparam logic [1:0] CYC_PLAIN  = 2'd1;
    localparam logic [1:0] CYC_BRANCH = 2'd3;

    typedef struct packed {
        logic        reg_write;
        logic [3:0]  reg_index;
        t_word       reg_value;
        logic [3:0]  nzcv;
        t_word       next_pc;
        logic        branch_taken;
        logic [1:0]  cycle_count;
        t_fault      fault_code;
        logic        exc_return;
        logic        breakpoint;
        logic        sleep_request;
        logic        mask_write;
        logic        mask_value;
    } t_result;

    function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] f);
        logic n, z, cf, v;
        n = f[3]; z = f[2]; cf = f[1]; v = f[0];
        unique case (c)
            4'd0:  cond_pass = z;
            4'd1:  cond_pass = !z;
            4'd2:  cond_pass = cf;
            4'd3:  cond_pass = !cf;
            4'd4:  cond_pass = n;
            4'd5:  cond_pass = !n;
            4'd6:  cond_pass = v;
            4'd7:  cond_pass = !v;
            4'd8:  cond_pass = cf && !z;
            4'd9:  cond_pass = !cf || z;
            4'd10: cond_pass = n == v;
            4'd11: cond_pass = n != v;
            4'd12: cond_pass = !z && (n == v);
            4'd13: cond_pass = z || (n != v);
            default: cond_pass = 1'b1;
        endcase
    endfunction
endpackage
`default_nettype wire

### rtl/core/cire_exec.sv
// Combinational execute logic for one halfword against the architectural state.
// Depends on cire_pkg.
`default_nettype none
module cire_exec (
    input  wire logic [15:0]        i_instr,
    input  wire cire_pkg::t_word    i_regs [16],
    input  wire logic [3:0]         i_flags,
    output cire_pkg::t_result       o_res
);
    import cire_pkg::*;

    t_word pc, lo_a, lo_b, rn3, hi_m, hi_d, addsub_b, add_r;
    logic  add_c, add_v, addsub_cin, use_add;
    logic [32:0] wide;
    logic [7:0]  s;
    logic [4:0]  imm5;
    logic [3:0]  rm4, rd4, sub;
    logic [63:0] shl64, shr64;
    logic [64:0] sar65;
    t_word r;
    logic  c;

    always_comb begin
        pc   = i_regs[15] + t_word'(2);
        lo_a = i_regs[{1'b0, i_instr[2:0]}];
        lo_b = i_regs[{1'b0, i_instr[5:3]}];
        rn3  = i_regs[{1'b0, i_instr[10:8]}];
        rm4  = i_instr[6:3];
        rd4  = {i_instr[7], i_instr[2:0]};
        hi_m = (rm4 == 4'd15) ? pc + t_word'(2) : i_regs[rm4];
        hi_d = (rd4 == 4'd15) ? pc + t_word'(2) : i_regs[rd4];
        s    = lo_b[7:0];
        imm5 = i_instr[10:6];
        sub  = i_instr[11:8];

        // Shared adder operand select.
        use_add    = 1'b0;
        add_r      = lo_b;
        addsub_b   = '0;
        addsub_cin = 1'b0;
        if (i_instr[15:13] == 3'b000 && i_instr[12:11] == 2'b11) begin
            use_add    = 1'b1;
            add_r      = lo_b;
            addsub_b   = i_instr[10] ? t_word'(i_instr[8:6])
                                     : i_regs[{1'b0, i_instr[8:6]}];
            if (i_instr[9]) begin
                addsub_b = ~addsub_b; addsub_cin = 1'b1;
            end
        end else if (i_instr[15:13] == 3'b001) begin
            use_add  = i_instr[12:11] != 2'b00;
            add_r    = rn3;
            addsub_b = t_word'(i_instr[7:0]);
            if (i_instr[12:11] != 2'b10) begin
                addsub_b = ~addsub_b; addsub_cin = 1'b1;
            end
        end else if (i_instr[15:10] == 6'h10) begin
            unique case (i_instr[9:6])
                4'd5:  begin add_r = lo_a; addsub_b = lo_b;  addsub_cin = i_flags[1]; end
                4'd6:  begin add_r = lo_a; addsub_b = ~lo_b; addsub_cin = i_flags[1]; end
                4'd9:  begin add_r = '0;   addsub_b = ~lo_b; addsub_cin = 1'b1; end
                4'd10: begin add_r = lo_a; addsub_b = ~lo_b; addsub_cin = 1'b1; end
                4'd11: begin add_r = lo_a; addsub_b = lo_b;  addsub_cin = 1'b0; end
                default: begin add_r = lo_a; addsub_b = lo_b; addsub_cin = 1'b0; end
            endcase
        end else begin
            add_r = hi_d; addsub_b = ~hi_m; addsub_cin = 1'b1;
        end
        wide  = {1'b0, add_r} + {1'b0, addsub_b} + 33'(addsub_cin);
        add_c = wide[32];
        add_v = (~(add_r[31] ^ addsub_b[31])) & (add_r[31] ^ wide[31]);

        o_res = '0;
        o_res.nzcv        = i_flags;
        o_res.next_pc     = pc;
        o_res.cycle_count = CYC_PLAIN;
        o_res.fault_code  = FAULT_NONE;
        shl64 = '0; shr64 = '0; sar65 = '0; r = '0; c = 1'b0;

        priority if (i_instr[15:13] == 3'b000) begin
            if (use_add) begin
                o_res.reg_write = 1'b1; o_res.reg_index = {1'b0, i_instr[2:0]};
                o_res.reg_value = wide[31:0];
                o_res.nzcv = {wide[31], wide[31:0] == '0, add_c, add_v};
            end else begin
                c     = i_flags[1];
                shl64 = {32'd0, lo_b} << imm5;
                shr64 = {lo_b, 32'd0} >> imm5;
                sar65 = $signed({lo_b, 33'd0}) >>> imm5;
                unique case (i_instr[12:11])
                    2'b00: begin
                        r = shl64[31:0];
                        if (imm5 != 5'd0) c = shl64[32];
                    end
                    2'b01: begin
                        r = (imm5 == 5'd0) ? '0 : shr64[63:32];
                        c = (imm5 == 5'd0) ? lo_b[31] : shr64[31];
                    end
                    default: begin
                        r = (imm5 == 5'd0) ? {32{lo_b[31]}} : sar65[64:33];
                        c = (imm5 == 5'd0) ? lo_b[31] : sar65[32];
                    end
                endcase
                o_res.reg_write = 1'b1; o_res.reg_index = {1'b0, i_instr[2:0]};
                o_res.reg_value = r;
                o_res.nzcv = {r[31], r == '0, c, i_flags[0]};
            end
        end else if (i_instr[15:13] == 3'b001) begin
            if (i_instr[12:11] == 2'b00) begin
                o_res.reg_write = 1'b1; o_res.reg_index = {1'b0, i_instr[10:8]};
                o_res.reg_value = t_word'(i_instr[7:0]);
                o_res.nzcv = {1'b0, i_instr[7:0] == 8'd0, i_flags[1:0]};
            end else begin
                o_res.nzcv = {wide[31], wide[31:0] == '0, add_c, add_v};
                if (i_instr[12:11] != 2'b01) begin
                    o_res.reg_write = 1'b1; o_res.reg_index = {1'b0, i_instr[10:8]};
                    o_res.reg_value = wide[31:0];
                end
            end
        end else if (i_instr[15:10] == 6'h10) begin
            c = i_flags[1];
            o_res.reg_write = 1'b1; o_res.reg_index = {1'b0, i_instr[2:0]};
            shl64 = {32'd0, lo_a} << s[5:0];
            shr64 = {lo_a, 32'd0} >> s[5:0];
            sar65 = $signed({lo_a, 33'd0}) >>> s[5:0];
            unique case (i_instr[9:6])
                4'd0:  r = lo_a & lo_b;
                4'd1:  r = lo_a ^ lo_b;
                4'd2: begin
                    if (s == 8'd0) r = lo_a;
                    else if (s < 8'd32) begin r = shl64[31:0]; c = shl64[32]; end
                    else begin r = '0; c = (s == 8'd32) ? lo_a[0] : 1'b0; end
                end
                4'd3: begin
                    if (s == 8'd0) r = lo_a;
                    else if (s < 8'd32) begin r = shr64[63:32]; c = shr64[31]; end
                    else begin r = '0; c = (s == 8'd32) ? lo_a[31] : 1'b0; end
                end
                4'd4: begin
                    if (s == 8'd0) r = lo_a;
                    else if (s < 8'd32) begin r = sar65[64:33]; c = sar65[32]; end
                    else begin r = {32{lo_a[31]}}; c = lo_a[31]; end
                end
                4'd7: begin
                    r = (lo_a >> s[4:0]) | (lo_a << (6'd32 - {1'b0, s[4:0]}));
                    if (s[4:0] == 5'd0) r = lo_a;
                    if (s != 8'd0) c = r[31];
                end
                4'd8: begin r = lo_a & lo_b; o_res.reg_write = 1'b0; end
                4'd12: r = lo_a | lo_b;
                4'd13: r = lo_a * lo_b;
                4'd14: r = lo_a & ~lo_b;
                4'd15: r = ~lo_b;
                default: begin
                    r = wide[31:0];
                    if (i_instr[9:6] == 4'd10 || i_instr[9:6] == 4'd11)
                        o_res.reg_write = 1'b0;
                end
            endcase
            if (i_instr[9:6] == 4'd5 || i_instr[9:6] == 4'd6 || i_instr[9:6] == 4'd9
                || i_instr[9:6] == 4'd10 || i_instr[9:6] == 4'd11)
                o_res.nzcv = {wide[31], wide[31:0] == '0, add_c, add_v};
            else
                o_res.nzcv = {r[31], r == '0, c, i_flags[0]};
            if (!o_res.reg_write) o_res.reg_index = '0;
            else o_res.reg_value = r;
        end else if (i_instr[15:10] == 6'h11) begin
            unique case (i_instr[9:8])
                2'd1: o_res.nzcv = {wide[31], wide[31:0] == '0, add_c, add_v};
                2'd3: begin
                    if (i_instr[7]) begin
                        o_res.reg_write = 1'b1; o_res.reg_index = 4'd14;
                        o_res.reg_value = pc | t_word'(1);
                    end
                    o_res.next_pc      = {hi_m[31:1], 1'b0};
                    o_res.branch_taken = 1'b1;
                    o_res.cycle_count  = CYC_BRANCH;
                    o_res.exc_return   = hi_m[31:4] == 28'hFFFFFFF;
                end
                default: begin
                    r = (i_instr[9:8] == 2'd0) ? hi_d + hi_m : hi_m;
                    if (rd4 == 4'd15) begin
                        o_res.next_pc = {r[31:1], 1'b0}; o_res.branch_taken = 1'b1;
                    end else begin
                        o_res.reg_write = 1'b1; o_res.reg_index = rd4; o_res.reg_value = r;
                    end
                end
            endcase
        end else if (i_instr[15:11] == 5'h09 || i_instr[15:12] == 4'h5
                     || i_instr[15:13] == 3'h3 || i_instr[15:12] == 4'h8
                     || i_instr[15:12] == 4'h9 || i_instr[15:12] == 4'hC) begin
            o_res.fault_code = FAULT_NOT_HERE;
        end else if (i_instr[15:12] == 4'hA) begin
            o_res.reg_write = 1'b1; o_res.reg_index = {1'b0, i_instr[10:8]};
            o_res.reg_value = (i_instr[11] ? i_regs[13]
                               : ((pc + t_word'(2)) & ~t_word'(3)))
                              + t_word'({i_instr[7:0], 2'b00});
        end else if (i_instr[15:12] == 4'hB) begin
            unique case (sub)
                4'd0: begin
                    o_res.reg_write = 1'b1; o_res.reg_index = 4'd13;
                    o_res.reg_value = i_instr[7]
                        ? i_regs[13] - t_word'({i_instr[6:0], 2'b00})
                        : i_regs[13] + t_word'({i_instr[6:0], 2'b00});
                end
                4'd2: begin
                    o_res.reg_write = 1'b1; o_res.reg_index = {1'b0, i_instr[2:0]};
                    unique case (i_instr[7:6])
                        2'd0: o_res.reg_value = {{16{lo_b[15]}}, lo_b[15:0]};
                        2'd1: o_res.reg_value = {{24{lo_b[7]}}, lo_b[7:0]};
                        2'd2: o_res.reg_value = {16'd0, lo_b[15:0]};
                        default: o_res.reg_value = {24'd0, lo_b[7:0]};
                    endcase
                end
                4'd4, 4'd5, 4'd12, 4'd13: o_res.fault_code = FAULT_NOT_HERE;
                4'd14: o_res.breakpoint = 1'b1;
                4'd15: begin
                    if (i_instr[3:0] == 4'd0)
                        o_res.sleep_request = i_instr[7:4] == 4'd2 || i_instr[7:4] == 4'd3;
                end
                4'd1, 4'd3, 4'd9, 4'd11: begin
                    if (sub[3] ? (lo_a != '0) : (lo_a == '0)) begin
                        o_res.next_pc = pc + t_word'(2)
                            + t_word'({i_instr[9], i_instr[7:3], 1'b0});
                        o_res.branch_taken = 1'b1;
                    end
                end
                4'd6: begin
                    o_res.mask_write = 1'b1; o_res.mask_value = i_instr[4];
                end
                4'd10: begin
                    if (i_instr[7:6] != 2'd2) begin
                        o_res.reg_write = 1'b1; o_res.reg_index = {1'b0, i_instr[2:0]};
                    end
                    unique case (i_instr[7:6])
                        2'd0: o_res.reg_value = {lo_b[7:0], lo_b[15:8], lo_b[23:16], lo_b[31:24]};
                        2'd1: o_res.reg_value = {lo_b[23:16], lo_b[31:24], lo_b[7:0], lo_b[15:8]};
                        2'd3: o_res.reg_value = {{16{lo_b[7]}}, lo_b[7:0], lo_b[15:8]};
                        default: o_res.reg_value = '0;
                    endcase
                end
                default: o_res.fault_code = FAULT_BAD_MISC;
            endcase
        end else if (i_instr[15:12] == 4'hD) begin
            if (sub == 4'd14) o_res.fault_code = FAULT_BAD_COND;
            else if (sub == 4'd15) o_res.cycle_count = CYC_BRANCH;
            else if (cond_pass(sub, i_flags)) begin
                o_res.next_pc = pc + t_word'(2)
                    + {{23{i_instr[7]}}, i_instr[7:0], 1'b0};
                o_res.branch_taken = 1'b1;
                o_res.cycle_count  = CYC_BRANCH;
            end
        end else if (i_instr[15:11] == 5'h1C) begin
            o_res.next_pc = pc + t_word'(2) + {{20{i_instr[10]}}, i_instr[10:0], 1'b0};
            o_res.branch_taken = 1'b1;
            o_res.cycle_count  = CYC_BRANCH;
        end else begin
            o_res.fault_code = FAULT_UNDEF;
        end
    end
endmodule
`default_nettype wire

### rtl/core/compact_isa_register_execute.sv
// Top level of the compact instruction execute block: register file, flags,
// handshake and result register. Depends on cire_pkg and cire_exec.
//
// Usage: one 16-bit instruction halfword enters on the input channel
// (i_valid/o_ready/i_instr) and one result word leaves on the output channel
// (o_valid/i_ready plus the result ports). Each instruction is executed in
// the cycle it is accepted against the current register file and flags; the
// state is updated at the same edge and the result appears in the next cycle.
// Throughput is one instruction per cycle while the receiver keeps up; the
// path from register file read through the ALU and the 32 by 32 multiplier
// to the result register is combinational.
// An instruction is taken whenever the result register is empty or its word
// is taken in the same cycle; when the receiver stalls, the result holds and
// input acceptance stops until it is taken.
// Reset clears the register file, flags, interrupt mask and IT byte, and
// leaves the output channel empty.
`default_nettype none
module compact_isa_register_execute (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_instr,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_reg_write,
    output logic [3:0]       o_reg_index,
    output logic [31:0]      o_reg_value,
    output logic [3:0]       o_nzcv,
    output logic [31:0]      o_next_pc,
    output logic             o_branch_taken,
    output logic [1:0]       o_cycle_count,
    output logic [2:0]       o_fault_code,
    output logic             o_exc_return,
    output logic             o_breakpoint,
    output logic             o_sleep_request
);
    import cire_pkg::*;

    t_word   r_regs [16];
    logic [3:0] r_flags;
    logic    r_mask;
    logic [7:0] r_it;
    logic    r_valid;
    t_result r_res, n_res;
    logic    accept;

    cire_exec u_exec (
        .i_instr (i_instr),
        .i_regs  (r_regs),
        .i_flags (r_flags),
        .o_res   (n_res)
    );

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_regs[k] <= '0;
            r_flags <= '0;
            r_mask  <= 1'b0;
            r_it    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_flags    <= n_res.nzcv;
                r_regs[15] <= n_res.next_pc;
                if (n_res.reg_write) r_regs[n_res.reg_index] <= n_res.reg_value;
                if (n_res.mask_write) r_mask <= n_res.mask_value;
                // IT byte is kept only as state.
                if (i_instr[15:8] == 8'hBF && i_instr[3:0] != 4'd0) r_it <= i_instr[7:0];
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_res <= n_res;
    end

    assign o_valid         = r_valid;
    assign o_reg_write     = r_res.reg_write;
    assign o_reg_index     = r_res.reg_index;
    assign o_reg_value     = r_res.reg_value;
    assign o_nzcv          = r_res.nzcv;
    assign o_next_pc       = r_res.next_pc;
    assign o_branch_taken  = r_res.branch_taken;
    assign o_cycle_count   = r_res.cycle_count;
    assign o_fault_code    = r_res.fault_code;
    assign o_exc_return    = r_res.exc_return;
    assign o_breakpoint    = r_res.breakpoint;
    assign o_sleep_request = r_res.sleep_request ^ (r_mask & r_it[0] & 1'b0);
endmodule
`default_nettype wire
